@@ design/rfla_pkg.sv @@
// Shared constants, codes and controller/datapath interface types of the range allocator.
package rfla_pkg;

  localparam int MAX_RANGES = 16;
  localparam int INDEX_BITS = 16;

  // Width of the fields on the stream ports.
  localparam int FIELD_W = 16;
  localparam int STATUS_W = 2;

  localparam int ADDR_W  = $clog2(MAX_RANGES);
  localparam int CNT_W   = $clog2(MAX_RANGES + 1);
  localparam int FIRST_W = INDEX_BITS;
  localparam int LIMIT_W = INDEX_BITS + 1;
  localparam int ENTRY_W = FIRST_W + LIMIT_W;

  // Arithmetic width that holds any start, end, limit or size without overflow.
  localparam int CALC_W = ((INDEX_BITS > FIELD_W) ? INDEX_BITS : FIELD_W) + 1;

  localparam logic [CALC_W-1:0] SPACE_SIZE = CALC_W'(1) << INDEX_BITS;

  localparam int IN_DATA_W  = 2 * FIELD_W;
  localparam int OUT_FLD_W  = FIELD_W + STATUS_W + 1;
  localparam int OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;

  typedef enum logic [0:0] {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_ALLOC_FAIL = 2'd1,
    ST_TABLE_FULL = 2'd2,
    ST_NO_SPACE   = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    CMD_NONE       = 4'd0,
    CMD_ACCEPT     = 4'd1,
    CMD_WALK_NEXT  = 4'd2,
    CMD_FAIL       = 4'd3,
    CMD_EXT_FIRST  = 4'd4,
    CMD_EXT_LIMIT  = 4'd5,
    CMD_SHUP_START = 4'd6,
    CMD_SHUP_STEP  = 4'd7,
    CMD_INSERT     = 4'd8,
    CMD_APPEND     = 4'd9,
    CMD_TRIM_HEAD  = 4'd10,
    CMD_DROP_ONLY  = 4'd11,
    CMD_DROP_HEAD  = 4'd12,
    CMD_SHDN_STEP  = 4'd13,
    CMD_OUT_LOAD   = 4'd14
  } dp_cmd_e;

  typedef struct packed {
    dp_cmd_e cmd;
    status_e code;
  } rfla_cmd_t;

  typedef struct packed {
    logic is_free;
    logic no_space;
    logic count_zero;
    logic count_one;
    logic full;
    logic alloc_fit;
    logic alloc_drop;
    logic hit_first;
    logic hit_limit;
    logic above;
    logic last_idx;
    logic up_done;
    logic down_done;
    logic out_free;
  } rfla_flags_t;

endpackage

@@ design/rfla_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module rfla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/rfla_dp.sv @@
// Datapath of the range allocator: request registers, range RAM, pointers and result register.
module rfla_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rfla_pkg::rfla_cmd_t           cmd_i,
  output rfla_pkg::rfla_flags_t         flags_o,
  input  logic                          op_i,
  input  logic [rfla_pkg::FIELD_W-1:0]  block_start_i,
  input  logic [rfla_pkg::FIELD_W-1:0]  block_size_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [rfla_pkg::FIELD_W-1:0]  granted_index_o,
  output logic [rfla_pkg::STATUS_W-1:0] status_o,
  output logic                          table_empty_o
);

  localparam int AW = rfla_pkg::ADDR_W;
  localparam int CW = rfla_pkg::CNT_W;
  localparam int XW = rfla_pkg::CALC_W;
  localparam int FW = rfla_pkg::FIRST_W;
  localparam int LW = rfla_pkg::LIMIT_W;
  localparam int EW = rfla_pkg::ENTRY_W;
  localparam int DW = rfla_pkg::FIELD_W;

  logic                      op_q;
  logic [DW-1:0]             start_q, size_q;
  rfla_pkg::status_e         status_q, status_d;
  logic [DW-1:0]             granted_q, granted_d;
  logic [CW-1:0]             count_q, count_d;
  logic [AW-1:0]             idx_q, idx_d;
  logic [AW-1:0]             pos_q, pos_d;
  logic [AW-1:0]             wr_ptr_q, wr_ptr_d;

  logic                      out_valid_q, out_valid_d;
  logic [DW-1:0]             out_granted_q;
  logic [rfla_pkg::STATUS_W-1:0] out_status_q;
  logic                      out_empty_q;

  logic                      we;
  logic [AW-1:0]             waddr, raddr;
  logic [EW-1:0]             wdata, rdata;
  logic [FW-1:0]             rd_first;
  logic [LW-1:0]             rd_limit;
  logic [XW-1:0]             first_c, limit_c, start_c, size_c, end_c, nf_c, ext_c;
  logic                      out_free;

  rfla_ram #(
    .WIDTH (EW),
    .DEPTH (rfla_pkg::MAX_RANGES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign rd_first = rdata[FW-1:0];
  assign rd_limit = rdata[EW-1:FW];
  assign first_c  = XW'(rd_first);
  assign limit_c  = XW'(rd_limit);
  assign start_c  = XW'(start_q);
  assign size_c   = XW'(size_q);
  assign end_c    = start_c + size_c;
  assign nf_c     = first_c + size_c;
  assign ext_c    = limit_c + size_c;
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    flags_o.is_free    = (op_q == rfla_pkg::OP_FREE);
    flags_o.no_space   = (start_c >= rfla_pkg::SPACE_SIZE) || (end_c > rfla_pkg::SPACE_SIZE);
    flags_o.count_zero = (count_q == '0);
    flags_o.count_one  = (count_q == CW'(1));
    flags_o.full       = (count_q == CW'(rfla_pkg::MAX_RANGES));
    flags_o.alloc_fit  = (limit_c >= first_c) && ((limit_c - first_c) >= size_c);
    flags_o.alloc_drop = (nf_c >= limit_c);
    flags_o.hit_first  = (first_c == end_c);
    flags_o.hit_limit  = (limit_c == start_c);
    flags_o.above      = (first_c > start_c);
    flags_o.last_idx   = ((CW'(idx_q) + CW'(1)) == count_q);
    flags_o.up_done    = ((wr_ptr_q - AW'(1)) == pos_q);
    flags_o.down_done  = ((CW'(wr_ptr_q) + CW'(1)) == count_q);
    flags_o.out_free   = out_free;
  end

  // RAM port control.
  always_comb begin
    we    = 1'b0;
    waddr = idx_q;
    wdata = rdata;
    raddr = '0;
    unique case (cmd_i.cmd)
      rfla_pkg::CMD_ACCEPT:     raddr = '0;
      rfla_pkg::CMD_WALK_NEXT:  raddr = idx_q + AW'(1);
      rfla_pkg::CMD_EXT_FIRST: begin
        we    = 1'b1;
        wdata = {rd_limit, start_c[FW-1:0]};
      end
      rfla_pkg::CMD_EXT_LIMIT: begin
        we    = 1'b1;
        wdata = {ext_c[LW-1:0], rd_first};
      end
      rfla_pkg::CMD_SHUP_START: raddr = AW'(count_q - CW'(1));
      rfla_pkg::CMD_SHUP_STEP: begin
        we    = 1'b1;
        waddr = wr_ptr_q;
        raddr = wr_ptr_q - AW'(2);
      end
      rfla_pkg::CMD_INSERT: begin
        we    = 1'b1;
        waddr = pos_q;
        wdata = {end_c[LW-1:0], start_c[FW-1:0]};
      end
      rfla_pkg::CMD_APPEND: begin
        we    = 1'b1;
        waddr = AW'(count_q);
        wdata = {end_c[LW-1:0], start_c[FW-1:0]};
      end
      rfla_pkg::CMD_TRIM_HEAD: begin
        we    = 1'b1;
        waddr = '0;
        wdata = {rd_limit, nf_c[FW-1:0]};
      end
      rfla_pkg::CMD_DROP_HEAD:  raddr = AW'(1);
      rfla_pkg::CMD_SHDN_STEP: begin
        we    = 1'b1;
        waddr = wr_ptr_q;
        raddr = AW'(CW'(wr_ptr_q) + CW'(2));
      end
      default: ;
    endcase
  end

  // Register next values.
  always_comb begin
    status_d    = status_q;
    granted_d   = granted_q;
    count_d     = count_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    wr_ptr_d    = wr_ptr_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (cmd_i.cmd)
      rfla_pkg::CMD_ACCEPT: begin
        status_d  = rfla_pkg::ST_OK;
        granted_d = '0;
        idx_d     = '0;
      end
      rfla_pkg::CMD_WALK_NEXT:  idx_d = idx_q + AW'(1);
      rfla_pkg::CMD_FAIL:       status_d = cmd_i.code;
      rfla_pkg::CMD_SHUP_START: begin
        pos_d    = idx_q;
        wr_ptr_d = AW'(count_q);
      end
      rfla_pkg::CMD_SHUP_STEP:  wr_ptr_d = wr_ptr_q - AW'(1);
      rfla_pkg::CMD_INSERT,
      rfla_pkg::CMD_APPEND:     count_d = count_q + CW'(1);
      rfla_pkg::CMD_TRIM_HEAD:  granted_d = first_c[DW-1:0];
      rfla_pkg::CMD_DROP_ONLY: begin
        granted_d = first_c[DW-1:0];
        count_d   = count_q - CW'(1);
      end
      rfla_pkg::CMD_DROP_HEAD: begin
        granted_d = first_c[DW-1:0];
        count_d   = count_q - CW'(1);
        wr_ptr_d  = '0;
      end
      rfla_pkg::CMD_SHDN_STEP:  wr_ptr_d = wr_ptr_q + AW'(1);
      rfla_pkg::CMD_OUT_LOAD:   out_valid_d = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cmd == rfla_pkg::CMD_ACCEPT) begin
      op_q    <= op_i;
      start_q <= block_start_i;
      size_q  <= block_size_i;
    end
    if (cmd_i.cmd == rfla_pkg::CMD_OUT_LOAD) begin
      out_granted_q <= granted_q;
      out_status_q  <= status_q;
      out_empty_q   <= (count_q == '0);
    end
    status_q  <= status_d;
    granted_q <= granted_d;
    idx_q     <= idx_d;
    pos_q     <= pos_d;
    wr_ptr_q  <= wr_ptr_d;
  end

  assign out_valid_o     = out_valid_q;
  assign granted_index_o = out_granted_q;
  assign status_o        = out_status_q;
  assign table_empty_o   = out_empty_q;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(rfla_pkg::MAX_RANGES))
    else $error("range count above table size");

  a_no_grow_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.cmd == rfla_pkg::CMD_INSERT || cmd_i.cmd == rfla_pkg::CMD_APPEND)
    |-> !flags_o.full)
    else $error("new range written into a full table");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |->
    (count_q == $past(count_q) + CW'(1) || count_q == $past(count_q) - CW'(1)))
    else $error("range count moved by more than one");

  a_shift_up_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.cmd == rfla_pkg::CMD_SHUP_STEP) |-> (wr_ptr_q != pos_q))
    else $error("shift up ran past the insert position");
`endif

endmodule

@@ design/rfla_ctrl.sv @@
// Controller state machine of the range allocator.
module rfla_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  rfla_pkg::rfla_flags_t flags_i,
  output rfla_pkg::rfla_cmd_t   cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_EVAL = 7'b0000010,
    S_WALK = 7'b0000100,
    S_SHUP = 7'b0001000,
    S_INS  = 7'b0010000,
    S_SHDN = 7'b0100000,
    S_RES  = 7'b1000000
  } state_e;

  state_e              state_q, state_d;
  rfla_pkg::rfla_cmd_t walk_cmd;
  state_e              walk_next;

  // One step of the free walk over the entry currently on the RAM read port.
  always_comb begin
    walk_cmd.cmd  = rfla_pkg::CMD_WALK_NEXT;
    walk_cmd.code = rfla_pkg::ST_OK;
    walk_next     = S_WALK;
    priority if (flags_i.hit_first) begin
      walk_cmd.cmd = rfla_pkg::CMD_EXT_FIRST;
      walk_next    = S_RES;
    end else if (flags_i.hit_limit) begin
      walk_cmd.cmd = rfla_pkg::CMD_EXT_LIMIT;
      walk_next    = S_RES;
    end else if (flags_i.above || flags_i.last_idx) begin
      if (flags_i.full) begin
        walk_cmd.cmd  = rfla_pkg::CMD_FAIL;
        walk_cmd.code = rfla_pkg::ST_TABLE_FULL;
        walk_next     = S_RES;
      end else if (flags_i.above) begin
        walk_cmd.cmd = rfla_pkg::CMD_SHUP_START;
        walk_next    = S_SHUP;
      end else begin
        walk_cmd.cmd = rfla_pkg::CMD_APPEND;
        walk_next    = S_RES;
      end
    end else begin
      walk_cmd.cmd = rfla_pkg::CMD_WALK_NEXT;
      walk_next    = S_WALK;
    end
  end

  always_comb begin
    cmd_o.cmd  = rfla_pkg::CMD_NONE;
    cmd_o.code = rfla_pkg::ST_OK;
    state_d    = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.cmd = rfla_pkg::CMD_ACCEPT;
          state_d   = S_EVAL;
        end
      end
      S_EVAL: begin
        if (!flags_i.is_free) begin
          if (flags_i.count_zero || !flags_i.alloc_fit) begin
            cmd_o.cmd  = rfla_pkg::CMD_FAIL;
            cmd_o.code = rfla_pkg::ST_ALLOC_FAIL;
            state_d    = S_RES;
          end else if (!flags_i.alloc_drop) begin
            cmd_o.cmd = rfla_pkg::CMD_TRIM_HEAD;
            state_d   = S_RES;
          end else if (flags_i.count_one) begin
            cmd_o.cmd = rfla_pkg::CMD_DROP_ONLY;
            state_d   = S_RES;
          end else begin
            cmd_o.cmd = rfla_pkg::CMD_DROP_HEAD;
            state_d   = S_SHDN;
          end
        end else if (flags_i.no_space) begin
          cmd_o.cmd  = rfla_pkg::CMD_FAIL;
          cmd_o.code = rfla_pkg::ST_NO_SPACE;
          state_d    = S_RES;
        end else if (flags_i.count_zero) begin
          cmd_o.cmd = rfla_pkg::CMD_APPEND;
          state_d   = S_RES;
        end else begin
          cmd_o   = walk_cmd;
          state_d = walk_next;
        end
      end
      S_WALK: begin
        cmd_o   = walk_cmd;
        state_d = walk_next;
      end
      S_SHUP: begin
        cmd_o.cmd = rfla_pkg::CMD_SHUP_STEP;
        if (flags_i.up_done) begin
          state_d = S_INS;
        end
      end
      S_INS: begin
        cmd_o.cmd = rfla_pkg::CMD_INSERT;
        state_d   = S_RES;
      end
      S_SHDN: begin
        cmd_o.cmd = rfla_pkg::CMD_SHDN_STEP;
        if (flags_i.down_done) begin
          state_d = S_RES;
        end
      end
      S_RES: begin
        if (flags_i.out_free) begin
          cmd_o.cmd = rfla_pkg::CMD_OUT_LOAD;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

`ifndef SYNTH
  a_accept_leads_to_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_EVAL))
    else $error("accepted word not evaluated in the next cycle");

  a_result_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.cmd == rfla_pkg::CMD_OUT_LOAD) |-> flags_i.out_free)
    else $error("result loaded over a pending result");

  a_shift_down_only_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHDN) |-> !flags_i.is_free)
    else $error("head shift running on a free");
`endif

endmodule

@@ design/range_free_list_allocator.sv @@
// Top level of the free index range allocator with stream input and output channels.
//
// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tdata: block_start, block_size; tuser: op
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata: granted_index, status, table_empty
//
// One word is processed at a time. An allocate accepts the word, evaluates it and loads the
// result, and moves the remaining ranges down one at a time when the head range is used up
// and others remain (up to MAX_RANGES - 1). A free walks the ranges in order from the first;
// an insert then moves each range above the new one up and writes the new range. The range
// table is a RAM with one write and one registered read port, and each walk and shift step
// is one access to it.
// Reset clears the range count and the handshake state; the table itself needs no clearing.
// A result waits in the output register while m_axis_tready is low; the next word is
// accepted meanwhile and stalls only when its own result is ready to load.
module range_free_list_allocator (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // Bits from the lowest up: block_start [15:0], block_size [31:16].
  input  logic [rfla_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // Bit 0: op (0 allocate, 1 free).
  input  logic                             s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // Bits from the lowest up: granted_index [15:0], status [17:16], table_empty [18],
  // zero padding above.
  output logic [rfla_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

  localparam int DW = rfla_pkg::FIELD_W;
  localparam int SW = rfla_pkg::STATUS_W;

  rfla_pkg::rfla_cmd_t   cmd;
  rfla_pkg::rfla_flags_t flags;
  logic [DW-1:0]         granted_index;
  logic [SW-1:0]         status;
  logic                  table_empty;

  // The controller sequences each word; the datapath holds the table and does the compares.
  rfla_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .flags_i    (flags),
    .cmd_o      (cmd)
  );

  rfla_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .flags_o         (flags),
    .op_i            (s_axis_tuser),
    .block_start_i   (s_axis_tdata[DW-1:0]),
    .block_size_i    (s_axis_tdata[2*DW-1:DW]),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .granted_index_o (granted_index),
    .status_o        (status),
    .table_empty_o   (table_empty)
  );

  // Pack the result fields from the lowest bit up and pad to whole bytes.
  assign m_axis_tdata = rfla_pkg::OUT_DATA_W'({table_empty, status, granted_index});

endmodule
